### rtl/bcdce_pkg.sv
// bcdce_pkg: shared types, codes and constants for the BCD clock field editor.
// Used by bcdce_field_step, bcd_clock_field_editor, bcdce_checker and the testbench.
`timescale 1ns / 1ps

package bcdce_pkg;

    localparam int unsigned OP_W    = 2;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned SLOT_W  = 4;
    localparam int unsigned ADDR_W  = 3;

    localparam logic [OP_W-1:0] OP_LEFT  = 2'd0;
    localparam logic [OP_W-1:0] OP_RIGHT = 2'd1;
    localparam logic [OP_W-1:0] OP_INC   = 2'd2;
    localparam logic [OP_W-1:0] OP_DEC   = 2'd3;

    localparam logic [SLOT_W-1:0] SLOT_REST    = 4'd0;
    localparam logic [SLOT_W-1:0] SLOT_YEAR    = 4'd1;
    localparam logic [SLOT_W-1:0] SLOT_MONTH   = 4'd2;
    localparam logic [SLOT_W-1:0] SLOT_DATE    = 4'd3;
    localparam logic [SLOT_W-1:0] SLOT_WEEKDAY = 4'd4;
    localparam logic [SLOT_W-1:0] SLOT_HOUR    = 4'd5;
    localparam logic [SLOT_W-1:0] SLOT_MINUTE  = 4'd6;
    localparam logic [SLOT_W-1:0] SLOT_SECOND  = 4'd7;
    localparam logic [SLOT_W-1:0] SLOT_AMPM    = 4'd8;
    localparam logic [SLOT_W-1:0] SLOT_COUNT   = 4'd9;

    localparam logic [ADDR_W-1:0] REG_SECOND  = 3'd0;
    localparam logic [ADDR_W-1:0] REG_MINUTE  = 3'd1;
    localparam logic [ADDR_W-1:0] REG_HOUR    = 3'd2;
    localparam logic [ADDR_W-1:0] REG_WEEKDAY = 3'd3;
    localparam logic [ADDR_W-1:0] REG_DATE    = 3'd4;
    localparam logic [ADDR_W-1:0] REG_MONTH   = 3'd5;
    localparam logic [ADDR_W-1:0] REG_YEAR    = 3'd6;

    localparam logic [BYTE_W-1:0] YEAR_MAX   = 8'h99;
    localparam logic [BYTE_W-1:0] MONTH_MAX  = 8'h12;
    localparam logic [BYTE_W-1:0] DATE_MAX   = 8'h31;
    localparam logic [BYTE_W-1:0] MINSEC_MAX = 8'h59;
    localparam logic [BYTE_W-1:0] WDAY_MAX   = 8'h07;
    localparam logic [BYTE_W-1:0] FIELD_ZERO = 8'h00;
    localparam logic [BYTE_W-1:0] FIELD_ONE  = 8'h01;
    localparam logic [BYTE_W-1:0] HOUR_MODE  = 8'hE0;
    localparam logic [BYTE_W-1:0] HOUR_MASK  = 8'h1F;
    localparam logic [BYTE_W-1:0] PM_BIT     = 8'h20;
    localparam logic [BYTE_W-1:0] PM_CLEAR   = 8'hDF;

    typedef struct packed {
        logic [SLOT_W-1:0] cursor_slot;
        logic [ADDR_W-1:0] register_address;
        logic              write_enable;
        logic [BYTE_W-1:0] write_value;
    } t_result;

    function automatic logic [ADDR_W-1:0] slot_reg(input logic [SLOT_W-1:0] slot);
        logic [ADDR_W-1:0] a;
        unique case (slot)
            SLOT_YEAR:    a = REG_YEAR;
            SLOT_MONTH:   a = REG_MONTH;
            SLOT_DATE:    a = REG_DATE;
            SLOT_WEEKDAY: a = REG_WEEKDAY;
            SLOT_HOUR:    a = REG_HOUR;
            SLOT_MINUTE:  a = REG_MINUTE;
            SLOT_SECOND:  a = REG_SECOND;
            SLOT_AMPM:    a = REG_HOUR;
            default:      a = REG_SECOND;
        endcase
        return a;
    endfunction

    // binary byte to packed BCD, tens digit truncated to a nibble
    function automatic logic [BYTE_W-1:0] bin_to_bcd(input logic [BYTE_W-1:0] bin);
        logic [15:0] prod;
        logic [4:0]  q;
        logic [BYTE_W-1:0] r;
        prod = {8'd0, bin} * 16'd205;
        q    = prod[15:11];
        r    = bin - ({3'd0, q} * 8'd10);
        return {q[3:0], r[3:0]};
    endfunction

endpackage

### rtl/bcdce_field_step.sv
// bcdce_field_step: cursor move and per-field BCD edit for one transfer.
// Depends on bcdce_pkg.
`timescale 1ns / 1ps

module bcdce_field_step (
    input  logic [bcdce_pkg::SLOT_W-1:0] i_cursor,
    input  logic [bcdce_pkg::OP_W-1:0]   i_operation,
    input  logic [bcdce_pkg::BYTE_W-1:0] i_field_value,
    output bcdce_pkg::t_result           o_result
);
    import bcdce_pkg::*;

    logic [BYTE_W-1:0] v;
    logic [BYTE_W-1:0] bin;
    logic [BYTE_W-1:0] bcd_up;
    logic [BYTE_W-1:0] bcd_dn;
    logic              up;
    logic              in_ring;
    logic [SLOT_W-1:0] cur;
    logic [BYTE_W-1:0] wv;

    assign v       = i_field_value;
    assign up      = (i_operation == OP_INC);
    assign in_ring = (i_cursor < SLOT_COUNT);
    assign bin     = ({4'd0, v[7:4]} * 8'd10) + {4'd0, v[3:0]};
    assign bcd_up  = bin_to_bcd(bin + 8'd1);
    assign bcd_dn  = bin_to_bcd(bin - 8'd1);

    always_comb begin
        unique case (i_cursor)
            SLOT_YEAR:    wv = up ? ((v == YEAR_MAX) ? FIELD_ZERO : bcd_up)
                                  : ((v == FIELD_ZERO) ? YEAR_MAX : bcd_dn);
            SLOT_MONTH:   wv = up ? ((v == MONTH_MAX) ? FIELD_ONE : bcd_up)
                                  : ((v == FIELD_ONE) ? MONTH_MAX : bcd_dn);
            SLOT_DATE:    wv = up ? ((v == DATE_MAX) ? FIELD_ONE : bcd_up)
                                  : ((v == FIELD_ONE) ? DATE_MAX : bcd_dn);
            SLOT_WEEKDAY: wv = up ? ((v == WDAY_MAX) ? FIELD_ONE : v + 8'd1)
                                  : ((v == FIELD_ONE) ? WDAY_MAX : v - 8'd1);
            SLOT_HOUR: begin
                if (up) begin
                    wv = ((v & HOUR_MASK) == MONTH_MAX) ? ((v & HOUR_MODE) | FIELD_ONE)
                                                        : bcd_up;
                end else begin
                    wv = ((v & HOUR_MASK) == FIELD_ONE) ? ((v & HOUR_MODE) | MONTH_MAX)
                                                        : bcd_dn;
                end
            end
            SLOT_MINUTE, SLOT_SECOND:
                          wv = up ? ((v == MINSEC_MAX) ? FIELD_ZERO : bcd_up)
                                  : ((v == FIELD_ZERO) ? MINSEC_MAX : bcd_dn);
            SLOT_AMPM:    wv = ((v & PM_BIT) == FIELD_ZERO) ? (v | PM_BIT) : (v & PM_CLEAR);
            default:      wv = FIELD_ZERO;
        endcase
    end

    always_comb begin
        cur = i_cursor;
        o_result.write_enable = 1'b0;
        o_result.write_value  = FIELD_ZERO;
        unique case (i_operation)
            OP_LEFT: begin
                if (in_ring) begin
                    cur = (i_cursor == SLOT_REST) ? SLOT_AMPM : i_cursor - 4'd1;
                end
            end
            OP_RIGHT: begin
                if (in_ring) begin
                    cur = (i_cursor == SLOT_AMPM) ? SLOT_REST : i_cursor + 4'd1;
                end
            end
            default: begin
                if (in_ring && (i_cursor != SLOT_REST)) begin
                    o_result.write_enable = 1'b1;
                    o_result.write_value  = wv;
                end
            end
        endcase
        o_result.cursor_slot      = cur;
        o_result.register_address = slot_reg(cur);
    end

endmodule

### rtl/bcd_clock_field_editor.sv
// bcd_clock_field_editor: each input transfer is captured in the input register; its
// result is then computed by bcdce_field_step and held in the result register.
// Throughput one transfer per cycle while no result is stalled, set by the single pass
// through bcdce_field_step; an input waits only while i_stall holds a result.
// Reset (synchronous, active low) empties both stages and puts the cursor at rest.
// Depends on bcdce_pkg and bcdce_field_step.
`timescale 1ns / 1ps

module bcd_clock_field_editor (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [bcdce_pkg::OP_W-1:0]   i_operation,
    input  logic [bcdce_pkg::BYTE_W-1:0] i_field_value,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [bcdce_pkg::SLOT_W-1:0] o_cursor_slot,
    output logic [bcdce_pkg::ADDR_W-1:0] o_register_address,
    output logic                         o_write_enable,
    output logic [bcdce_pkg::BYTE_W-1:0] o_write_value
);
    import bcdce_pkg::*;

    logic              r_in_valid;
    logic [OP_W-1:0]   r_operation;
    logic [BYTE_W-1:0] r_field_value;
    logic [SLOT_W-1:0] r_cursor;
    logic              r_out_valid;
    t_result           r_result;
    t_result           n_result;
    logic              out_free;
    logic              advance;

    assign out_free = !r_out_valid || !i_stall;
    assign advance  = r_in_valid && out_free;
    assign o_stall  = r_in_valid && !out_free;

    bcdce_field_step u_step (
        .i_cursor      (r_cursor),
        .i_operation   (r_operation),
        .i_field_value (r_field_value),
        .o_result      (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_cursor    <= SLOT_REST;
        end else begin
            if (!o_stall) begin
                r_in_valid <= i_valid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
            if (advance) begin
                r_cursor <= n_result.cursor_slot;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_operation   <= i_operation;
            r_field_value <= i_field_value;
        end
        if (advance) begin
            r_result <= n_result;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_cursor_slot      = r_result.cursor_slot;
    assign o_register_address = r_result.register_address;
    assign o_write_enable     = r_result.write_enable;
    assign o_write_value      = r_result.write_value;

endmodule

### rtl/bcdce_checker.sv
// bcdce_checker: port-level assertions for bcd_clock_field_editor, and its bind.
// Depends on bcdce_pkg.
`timescale 1ns / 1ps

module bcdce_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         o_valid,
    input logic                         i_stall,
    input logic [bcdce_pkg::SLOT_W-1:0] o_cursor_slot,
    input logic [bcdce_pkg::ADDR_W-1:0] o_register_address,
    input logic                         o_write_enable,
    input logic [bcdce_pkg::BYTE_W-1:0] o_write_value
);
    import bcdce_pkg::*;

    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_cursor_slot < SLOT_COUNT))
        else $error("cursor slot out of ring");

    a_rest_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_cursor_slot == SLOT_REST)) |->
        (!o_write_enable && (o_register_address == REG_SECOND)
         && (o_write_value == FIELD_ZERO)))
        else $error("rest slot produced a write");

    a_move_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_write_enable) |-> (o_write_value == FIELD_ZERO))
        else $error("write value nonzero without write enable");

    a_ampm_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && ((o_cursor_slot == SLOT_HOUR) || (o_cursor_slot == SLOT_AMPM)))
        |-> (o_register_address == REG_HOUR))
        else $error("hour field mapped to wrong register");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_write_value)
                                   && $stable(o_cursor_slot)))
        else $error("stalled result changed");

endmodule

bind bcd_clock_field_editor bcdce_checker u_bcdce_checker (.*);

### tb/sv/bcdce_tb_pkg.sv
// bcdce_tb_pkg: scoreboard for the BCD clock field editor testbench.
// Tracks the cursor, predicts each result, and checks results in order.
// Depends on bcdce_pkg for codes, widths and the result record.
`timescale 1ns / 1ps

package bcdce_tb_pkg;

    import bcdce_pkg::*;

    class rtc_edit_scoreboard;

        logic [SLOT_W-1:0] cursor;
        t_result           pending_results[$];
        int                error_count;
        int                keys_seen;
        int                results_checked;
        bit [8:0]          slots_edited;

        function new();
            cursor          = SLOT_REST;
            error_count     = 0;
            keys_seen       = 0;
            results_checked = 0;
            slots_edited    = '0;
        endfunction

        static function logic [ADDR_W-1:0] reg_of_slot(logic [SLOT_W-1:0] slot);
            case (slot)
                SLOT_YEAR:    return REG_YEAR;
                SLOT_MONTH:   return REG_MONTH;
                SLOT_DATE:    return REG_DATE;
                SLOT_WEEKDAY: return REG_WEEKDAY;
                SLOT_HOUR:    return REG_HOUR;
                SLOT_MINUTE:  return REG_MINUTE;
                SLOT_AMPM:    return REG_HOUR;
                default:      return REG_SECOND;
            endcase
        endfunction

        static function logic [BYTE_W-1:0] bcd_bump(logic [BYTE_W-1:0] v, bit up);
            int b;
            b = (int'(v[7:4]) * 10 + int'(v[3:0])) % 256;
            b = up ? (b + 1) % 256 : (b + 255) % 256;
            return 8'(((b / 10) << 4) + (b % 10));
        endfunction

        static function logic [BYTE_W-1:0] bounded_bump(logic [BYTE_W-1:0] v, bit up,
                                                        logic [BYTE_W-1:0] lo,
                                                        logic [BYTE_W-1:0] hi);
            if (up)
                return (v == hi) ? lo : bcd_bump(v, 1'b1);
            return (v == lo) ? hi : bcd_bump(v, 1'b0);
        endfunction

        static function logic [BYTE_W-1:0] next_field_byte(logic [SLOT_W-1:0] slot,
                                                           logic [BYTE_W-1:0] v, bit up);
            case (slot)
                SLOT_YEAR:  return bounded_bump(v, up, FIELD_ZERO, YEAR_MAX);
                SLOT_MONTH: return bounded_bump(v, up, FIELD_ONE, MONTH_MAX);
                SLOT_DATE:  return bounded_bump(v, up, FIELD_ONE, DATE_MAX);
                SLOT_WEEKDAY: begin
                    if (up)
                        return (v == WDAY_MAX) ? FIELD_ONE : v + 8'd1;
                    return (v == FIELD_ONE) ? WDAY_MAX : v - 8'd1;
                end
                SLOT_HOUR: begin
                    if (up && (v & HOUR_MASK) == MONTH_MAX)
                        return (v & HOUR_MODE) + FIELD_ONE;
                    if (!up && (v & HOUR_MASK) == FIELD_ONE)
                        return (v & HOUR_MODE) + MONTH_MAX;
                    return bcd_bump(v, up);
                end
                SLOT_MINUTE, SLOT_SECOND:
                    return bounded_bump(v, up, FIELD_ZERO, MINSEC_MAX);
                default:
                    return ((v & PM_BIT) == 8'd0) ? (v | PM_BIT) : (v & PM_CLEAR);
            endcase
        endfunction

        function void note_key(logic [OP_W-1:0] op, logic [BYTE_W-1:0] value);
            t_result r;
            r = '0;
            keys_seen++;
            case (op)
                OP_LEFT: begin
                    if (cursor < SLOT_COUNT)
                        cursor = (cursor == SLOT_REST) ? SLOT_AMPM : cursor - 4'd1;
                end
                OP_RIGHT: begin
                    if (cursor < SLOT_COUNT)
                        cursor = (cursor == SLOT_AMPM) ? SLOT_REST : cursor + 4'd1;
                end
                default: begin
                    if (cursor != SLOT_REST && cursor < SLOT_COUNT) begin
                        r.write_enable = 1'b1;
                        r.write_value  = next_field_byte(cursor, value, op == OP_INC);
                        slots_edited[cursor] = 1'b1;
                    end
                end
            endcase
            r.cursor_slot      = cursor;
            r.register_address = (cursor < SLOT_COUNT) ? reg_of_slot(cursor) : REG_SECOND;
            pending_results.push_back(r);
        endfunction

        function void check_result(logic [SLOT_W-1:0] slot, logic [ADDR_W-1:0] addr,
                                   logic we, logic [BYTE_W-1:0] wv);
            t_result e;
            if (pending_results.size() == 0) begin
                $error("unexpected result: cursor_slot %0d register_address %0d", slot, addr);
                error_count++;
                return;
            end
            e = pending_results.pop_front();
            results_checked++;
            if (slot !== e.cursor_slot) begin
                $error("cursor_slot: expected %0d, got %0d", e.cursor_slot, slot);
                error_count++;
            end
            if (addr !== e.register_address) begin
                $error("register_address: expected %0d, got %0d", e.register_address, addr);
                error_count++;
            end
            if (we !== e.write_enable) begin
                $error("write_enable: expected %0b, got %0b", e.write_enable, we);
                error_count++;
            end
            if (wv !== e.write_value) begin
                $error("write_value: expected 0x%02h, got 0x%02h", e.write_value, wv);
                error_count++;
            end
        endfunction

        function void flag_leftovers();
            if (pending_results.size() != 0) begin
                $error("%0d expected results never arrived", pending_results.size());
                error_count++;
            end
        endfunction

    endclass

endpackage

### tb/sv/tb_bcd_clock_field_editor.sv
// tb_bcd_clock_field_editor: top-level testbench for the BCD clock field editor.
// Drives directed and random key transfers with random idling on both sides.
// Depends on bcdce_pkg, bcdce_tb_pkg and bcd_clock_field_editor.
`timescale 1ns / 1ps

module tb_bcd_clock_field_editor;

    import bcdce_pkg::*;
    import bcdce_tb_pkg::*;

    localparam int HOLD_CYCLES = 80;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_stall;
    logic [OP_W-1:0]     i_operation = OP_LEFT;
    logic [BYTE_W-1:0]   i_field_value = '0;
    logic                o_valid;
    logic                i_stall = 1'b0;
    logic [SLOT_W-1:0]   o_cursor_slot;
    logic [ADDR_W-1:0]   o_register_address;
    logic                o_write_enable;
    logic [BYTE_W-1:0]   o_write_value;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;

    rtc_edit_scoreboard sb;

    bcd_clock_field_editor i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_operation        (i_operation),
        .i_field_value      (i_field_value),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_cursor_slot      (o_cursor_slot),
        .o_register_address (o_register_address),
        .o_write_enable     (o_write_enable),
        .o_write_value      (o_write_value)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            i_stall   <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_served != hold_requests) begin
            i_stall     <= 1'b1;
            hold_served <= hold_served + 1;
            hold_left   <= HOLD_CYCLES - 1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall)
                sb.note_key(i_operation, i_field_value);
            if (o_valid && !i_stall)
                sb.check_result(o_cursor_slot, o_register_address, o_write_enable,
                                o_write_value);
        end
    end

    task automatic send_key(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_operation   <= op;
        i_field_value <= value;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
    endtask

    function automatic logic [BYTE_W-1:0] pick_field_value();
        logic [BYTE_W-1:0] v;
        case ($urandom_range(3))
            0, 1: v = {4'($urandom_range(9)), 4'($urandom_range(9))};
            2: begin
                case ($urandom_range(8))
                    0: v = FIELD_ZERO;
                    1: v = FIELD_ONE;
                    2: v = WDAY_MAX;
                    3: v = MONTH_MAX;
                    4: v = DATE_MAX;
                    5: v = MINSEC_MAX;
                    6: v = YEAR_MAX;
                    7: v = {3'($urandom_range(7)), MONTH_MAX[4:0]};
                    default: v = {3'($urandom_range(7)), FIELD_ONE[4:0]};
                endcase
            end
            default: v = 8'($urandom);
        endcase
        return v;
    endfunction

    task automatic run_random_keys(input int count, input bit with_hold);
        logic [OP_W-1:0] op;
        for (int k = 0; k < count; k++) begin
            if (with_hold && k == count / 2)
                hold_requests <= hold_requests + 1;
            if ($urandom_range(99) < 60)
                op = $urandom_range(1) ? OP_INC : OP_DEC;
            else
                op = $urandom_range(1) ? OP_LEFT : OP_RIGHT;
            send_key(op, pick_field_value());
        end
    endtask

    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        int guard;
        sb = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 24;
        recv_idle_pct <= 79;
        send_key(OP_INC, 8'hFF);
        send_key(OP_LEFT, 8'h00);
        send_key(OP_INC, 8'h12);
        send_key(OP_DEC, 8'hF2);
        send_key(OP_LEFT, 8'hA5);
        send_key(OP_INC, MINSEC_MAX);
        send_key(OP_DEC, FIELD_ZERO);
        send_key(OP_LEFT, 8'h5A);
        send_key(OP_INC, 8'hFF);
        send_key(OP_LEFT, 8'h00);
        send_key(OP_INC, 8'h72);
        send_key(OP_DEC, FIELD_ONE);
        send_key(OP_INC, 8'h09);
        send_key(OP_LEFT, 8'hFF);
        send_key(OP_INC, WDAY_MAX);
        send_key(OP_DEC, FIELD_ZERO);
        send_key(OP_LEFT, 8'h00);
        send_key(OP_INC, DATE_MAX);
        send_key(OP_DEC, FIELD_ONE);
        send_key(OP_LEFT, 8'h00);
        send_key(OP_DEC, FIELD_ONE);
        send_key(OP_INC, MONTH_MAX);
        send_key(OP_LEFT, 8'h00);
        send_key(OP_INC, YEAR_MAX);
        send_key(OP_RIGHT, 8'h00);

        run_random_keys(425, 1'b0);
        send_idle_pct = 79;
        recv_idle_pct <= 24;
        run_random_keys(425, 1'b0);
        send_idle_pct = 0;
        recv_idle_pct <= 0;
        run_random_keys(425, 1'b1);
        i_valid <= 1'b0;

        guard = 0;
        while (sb.pending_results.size() != 0 && guard < 20000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (5) @(posedge i_clk);
        sb.flag_leftovers();

        $display("Run covered %0d key transfers and %0d checked results, %0d long hold-off(s);",
                 sb.keys_seen, sb.results_checked, hold_served);
        $display("field edits reached slot mask 9'b%09b under three idling mixes.",
                 sb.slots_edited);
        if (sb.error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
